@@ src/tsn_pkg.sv @@
// shared types and constants for the nearest-texel repeat-wrap sampler
// no dependencies; imported by every module of the block
package tsn_pkg;

  // packed texel, red in the top byte as stored in the texel memory
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // request action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEX_WIDTH   = 2'd0,
    CFG_TEX_HEIGHT  = 2'd1,
    CFG_TEX_PRESENT = 2'd2
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int SIZE_W     = 9;
  localparam int COORD_W    = 32;
  localparam int WRAP_W     = 17;

  localparam logic [WRAP_W-1:0] ONE_Q16 = 17'h10000;

  // returned when no texture is loaded
  localparam rgba_t DEFAULT_TEXEL = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255};

  // response queue sizing
  localparam int RSP_DEPTH = 8;
  localparam int RSP_PTR_W = 3;
  localparam int RSP_CNT_W = 4;

  // per-stage control flags
  typedef struct packed {
    logic valid;
    logic wr;
    logic smp;
    logic dflt;
  } stage_ctl_t;

  // repeat wrap of a signed q15.16 coordinate into 0..1.0 (q1.16, 0..65536)
  function automatic logic [WRAP_W-1:0] wrap_coord(input logic [COORD_W-1:0] bits);
    logic [15:0] frac;
    frac = 16'(~bits[15:0] + 16'd1);
    if (bits[31]) begin
      return ONE_Q16 - {1'b0, frac};
    end else if (bits[30:17] == 14'd0 && (!bits[16] || bits[15:0] == 16'd0)) begin
      return bits[16:0];
    end else begin
      return {1'b0, bits[15:0]};
    end
  endfunction

endpackage

@@ src/tsn_if.sv @@
// request and response channel interfaces of the texel sampler
// standalone; payload fields only, no package types
interface tsn_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [7:0]         texel_column;
  logic [7:0]         texel_row;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;
  logic [7:0]         alpha_in;
  logic signed [31:0] coord_u;
  logic signed [31:0] coord_v;

  modport source (
    output valid, action, texel_column, texel_row, red_in, green_in, blue_in, alpha_in,
           coord_u, coord_v,
    input  ready
  );
  modport sink (
    input  valid, action, texel_column, texel_row, red_in, green_in, blue_in, alpha_in,
           coord_u, coord_v,
    output ready
  );
endinterface

interface tsn_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

@@ src/tsn_coord.sv @@
// two-stage front end: coordinate wrap, then texel index multiply
// depends on tsn_pkg
module tsn_coord #(
  parameter int MAX_TEX_WIDTH  = 256,
  parameter int MAX_TEX_HEIGHT = 256,
  parameter int CW             = 8,
  parameter int RW             = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            action,
  input  logic [7:0]                      texel_column,
  input  logic [7:0]                      texel_row,
  input  tsn_pkg::rgba_t                  texel_in,
  input  logic [tsn_pkg::COORD_W-1:0]     coord_u,
  input  logic [tsn_pkg::COORD_W-1:0]     coord_v,
  input  logic [tsn_pkg::SIZE_W-1:0]      tex_width,
  input  logic [tsn_pkg::SIZE_W-1:0]      tex_height,
  input  logic                            tex_present,
  output tsn_pkg::stage_ctl_t             ctl,
  output logic [CW-1:0]                   col,
  output logic [RW-1:0]                   row,
  output tsn_pkg::rgba_t                  texel
);
  import tsn_pkg::*;

  localparam logic [12:0] MAXW = 13'(MAX_TEX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_TEX_HEIGHT);
  localparam logic [13:0] LASTW = 14'(MAX_TEX_WIDTH - 1);
  localparam logic [13:0] LASTH = 14'(MAX_TEX_HEIGHT - 1);

  logic [12:0] w_sz, h_sz;
  logic [11:0] w_m1, h_m1;

  stage_ctl_t        s1_ctl;
  logic [7:0]        s1_col, s1_row;
  rgba_t             s1_texel;
  logic [WRAP_W-1:0] s1_u, s1_v;

  logic [29:0] prod_u, prod_v;
  logic [13:0] idx_u, idx_v;
  logic        in_range;

  // size registers: zero counts as one, saturate at the store size
  always_comb begin
    if (tex_width == '0) begin
      w_sz = 13'd1;
    end else if ({4'b0, tex_width} > MAXW) begin
      w_sz = MAXW;
    end else begin
      w_sz = {4'b0, tex_width};
    end
    if (tex_height == '0) begin
      h_sz = 13'd1;
    end else if ({4'b0, tex_height} > MAXH) begin
      h_sz = MAXH;
    end else begin
      h_sz = {4'b0, tex_height};
    end
    w_m1 = 12'(w_sz - 13'd1);
    h_m1 = 12'(h_sz - 13'd1);
  end

  // stage 1: wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.valid <= in_valid;
      s1_ctl.wr    <= in_valid && action == ACT_WRITE;
      s1_ctl.smp   <= in_valid && action == ACT_SAMPLE;
      s1_ctl.dflt  <= !tex_present;
    end
    s1_col   <= texel_column;
    s1_row   <= texel_row;
    s1_texel <= texel_in;
    s1_u     <= wrap_coord(coord_u);
    s1_v     <= wrap_coord(coord_v);
  end

  // stage 2: floor(wrapped * (size - 1))
  always_comb begin
    prod_u   = 30'(s1_u) * 30'(w_m1);
    prod_v   = 30'(s1_v) * 30'(h_m1);
    idx_u    = (prod_u[29:16] > LASTW) ? LASTW : prod_u[29:16];
    idx_v    = (prod_v[29:16] > LASTH) ? LASTH : prod_v[29:16];
    in_range = ({5'b0, s1_col} < MAXW) && ({5'b0, s1_row} < MAXH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= s1_ctl.valid;
      ctl.wr    <= s1_ctl.wr && in_range;
      ctl.smp   <= s1_ctl.smp;
      ctl.dflt  <= s1_ctl.dflt;
    end
    col   <= s1_ctl.smp ? CW'(idx_u) : CW'(s1_col);
    row   <= s1_ctl.smp ? RW'(idx_v) : RW'(s1_row);
    texel <= s1_texel;
  end

endmodule

@@ src/tsn_store.sv @@
// texel memory: one port, synchronous write, registered read
// depends on tsn_pkg
module tsn_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic           clk,
  input  logic           we,
  input  logic           re,
  input  logic [AW-1:0]  addr,
  input  tsn_pkg::rgba_t wdata,
  output tsn_pkg::rgba_t rdata
);
  import tsn_pkg::*;

  rgba_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ src/tsn_fifo.sv @@
// response queue in front of the output channel
// depends on tsn_pkg
module tsn_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  tsn_pkg::rgba_t                push_data,
  input  logic                          pop,
  output tsn_pkg::rgba_t                head,
  output logic [tsn_pkg::RSP_CNT_W-1:0] level
);
  import tsn_pkg::*;

  rgba_t                slots [RSP_DEPTH];
  logic [RSP_PTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + RSP_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RSP_PTR_W'(1);
      end
      level <= level + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign head = slots[rd_ptr];

endmodule

@@ src/texture_sample_nearest_repeat.sv @@
// top level of the nearest-texel sampler with repeat wrap
// depends on tsn_pkg, tsn_if, tsn_coord, tsn_store, tsn_fifo
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    action, texel_column/row, rgba in, coord_u/v
//  rsp      out  valid/ready    red_out, green_out, blue_out, alpha_out
//  cfg      in   cfg_we         cfg_index, cfg_data (no read-back)
//
// one request per cycle while req.ready is high; a sample passes the wrap and index
// stages, the memory read and the response queue before rsp.valid rises
// write and sample requests reach the texel memory at one stage in order, so a
// sample always sees every earlier write (no forwarding needed)
// rst is synchronous; the texel memory is not cleared and holds garbage until written
// the pipeline never stalls: a credit count over the 8-entry response queue drops
// req.ready once 8 samples are in flight or waiting, so rsp stalls never reach the memory
module texture_sample_nearest_repeat #(
  parameter int MAX_TEX_WIDTH  = 256,
  parameter int MAX_TEX_HEIGHT = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  tsn_req_if.sink                           req,
  tsn_rsp_if.source                         rsp,
  input  logic                              cfg_we,
  input  logic [tsn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsn_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tsn_pkg::*;

  localparam int DEPTH = MAX_TEX_WIDTH * MAX_TEX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_TEX_WIDTH > 1) ? $clog2(MAX_TEX_WIDTH) : 1;
  localparam int RW    = (MAX_TEX_HEIGHT > 1) ? $clog2(MAX_TEX_HEIGHT) : 1;

  // configuration registers
  logic [SIZE_W-1:0] tex_width, tex_height;
  logic              tex_present;

  // credit count: samples accepted and not yet delivered
  logic [RSP_CNT_W-1:0] outstanding;
  logic                 req_fire, smp_fire, rsp_fire;

  // stage 2 outputs of the front end
  stage_ctl_t    s2_ctl;
  logic [CW-1:0] s2_col;
  logic [RW-1:0] s2_row;
  rgba_t         s2_texel;

  // memory access
  logic [AW-1:0] mem_addr;
  logic          mem_we, mem_re;
  rgba_t         mem_rdata;

  // stage 3: read data is valid here
  stage_ctl_t s3_ctl;

  // response queue
  logic                 q_push;
  rgba_t                q_data, q_head;
  logic [RSP_CNT_W-1:0] q_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width   <= SIZE_W'(1);
      tex_height  <= SIZE_W'(1);
      tex_present <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEX_WIDTH:   tex_width   <= cfg_data[SIZE_W-1:0];
        CFG_TEX_HEIGHT:  tex_height  <= cfg_data[SIZE_W-1:0];
        CFG_TEX_PRESENT: tex_present <= cfg_data[0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  assign req_fire  = req.valid && req.ready;
  assign smp_fire  = req_fire && req.action == ACT_SAMPLE;
  assign rsp_fire  = rsp.valid && rsp.ready;
  assign req.ready = outstanding < RSP_CNT_W'(RSP_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + RSP_CNT_W'(smp_fire) - RSP_CNT_W'(rsp_fire);
    end
  end

  // wrap and index stages
  tsn_coord #(
    .MAX_TEX_WIDTH  (MAX_TEX_WIDTH),
    .MAX_TEX_HEIGHT (MAX_TEX_HEIGHT),
    .CW             (CW),
    .RW             (RW)
  ) u_coord (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req_fire),
    .action       (req.action),
    .texel_column (req.texel_column),
    .texel_row    (req.texel_row),
    .texel_in     ({req.red_in, req.green_in, req.blue_in, req.alpha_in}),
    .coord_u      (req.coord_u),
    .coord_v      (req.coord_v),
    .tex_width    (tex_width),
    .tex_height   (tex_height),
    .tex_present  (tex_present),
    .ctl          (s2_ctl),
    .col          (s2_col),
    .row          (s2_row),
    .texel        (s2_texel)
  );

  // row-major address; writes out of range already dropped in the front end
  assign mem_addr = AW'(AW'(s2_row) * AW'(MAX_TEX_WIDTH) + AW'(s2_col));
  assign mem_we   = s2_ctl.wr;
  assign mem_re   = s2_ctl.smp && !s2_ctl.dflt;

  tsn_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (s2_texel),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl <= '0;
    end else begin
      s3_ctl <= s2_ctl;
    end
  end

  // no texture loaded: opaque black
  assign q_push = s3_ctl.valid && s3_ctl.smp;
  assign q_data = s3_ctl.dflt ? DEFAULT_TEXEL : mem_rdata;

  tsn_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (rsp_fire),
    .head      (q_head),
    .level     (q_level)
  );

  assign rsp.valid     = q_level != '0;
  assign rsp.red_out   = q_head.red;
  assign rsp.green_out = q_head.green;
  assign rsp.blue_out  = q_head.blue;
  assign rsp.alpha_out = q_head.alpha;

  // credits keep the response queue from overflowing
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_level < RSP_CNT_W'(RSP_DEPTH))
    else $error("response queue push while full");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= RSP_CNT_W'(RSP_DEPTH) && q_level <= outstanding)
    else $error("credit count out of step with queue level");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("texel memory read and write in one cycle");

  a_push_follows_read: assert property (@(posedge clk) disable iff (rst)
    (q_push && !s3_ctl.dflt) |-> $past(mem_re))
    else $error("sample response without a memory read");

endmodule
